### sv/dda_pkg.sv
// Package for the DDA line rasteriser: default widths, opcodes and the
// divider control struct. Depends on nothing; every other file imports it.
`default_nettype none

package dda_pkg;

  // Default field widths.
  localparam int DDA_COORD_BITS = 16;
  localparam int DDA_FRAC_BITS  = 16;
  localparam int DDA_COLOR_BITS = 24;

  // Opcodes of an input transaction.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Control from the sequencer to one serial divider.
  typedef struct packed {
    logic load;   // take a new dividend and divisor
    logic shift;  // produce one more quotient bit
  } dda_div_ctrl_t;

endpackage

`default_nettype wire

### sv/dda_in_if.sv
// Input channel of the DDA line rasteriser: handshake plus one command.
// Depends on dda_pkg.
`default_nettype none

interface dda_in_if #(
  parameter int COORD_BITS = dda_pkg::DDA_COORD_BITS
);
  import dda_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [DDA_COLOR_BITS-1:0]    line_color;

  modport source (output valid, opcode, x_start, y_start, x_end, y_end, line_color,
                  input ready);
  modport sink   (input valid, opcode, x_start, y_start, x_end, y_end, line_color,
                  output ready);
endinterface

`default_nettype wire

### sv/dda_pix_if.sv
// Output channel of the DDA line rasteriser: handshake plus one pixel.
// Depends on dda_pkg.
`default_nettype none

interface dda_pix_if #(
  parameter int COORD_BITS = dda_pkg::DDA_COORD_BITS
);
  import dda_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [DDA_COLOR_BITS-1:0]    pixel_color;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

`default_nettype wire

### sv/dda_line_rasterizer.sv
// Top level of the DDA line rasteriser: load sequencer, position walk and
// output register. Depends on dda_pkg, dda_in_if, dda_pix_if and dda_div.
//
//   channel  direction  carries
//   in_i     sink       opcode, x_start, y_start, x_end, y_end, line_color
//   pix_o    source     pixel_x, pixel_y, pixel_color, last_pixel
//
// A step transaction is taken straight into the output register; a load starts
// the two bit-serial dividers that form one increment bit per cycle.
// Reset clears the sequencer, the active-line flag and the output valid.
// The pixel sits in an output register; input is accepted while that register
// is empty or being drained in the same cycle, and held off during a division.
`default_nettype none

module dda_line_rasterizer #(
  parameter int COORD_BITS = dda_pkg::DDA_COORD_BITS,
  parameter int FRAC_BITS  = dda_pkg::DDA_FRAC_BITS
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  dda_in_if.sink      in_i,
  dda_pix_if.source   pix_o
);
  import dda_pkg::*;

  localparam int POS_BITS = COORD_BITS + FRAC_BITS + 1;
  localparam int INC_BITS = FRAC_BITS + 2;
  localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                       state_q, state_d;
  logic [CNT_BITS-1:0]        cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       neg_x_q, neg_y_q, zero_q;
  logic signed [POS_BITS-1:0] pos_x_q, pos_y_q;
  logic [COORD_BITS-1:0]      left_q;
  logic [DDA_COLOR_BITS-1:0]  color_q;

  logic                       ovalid_q, ovalid_d;
  logic [COORD_BITS-1:0]      px_q, py_q;
  logic [DDA_COLOR_BITS-1:0]  pcol_q;
  logic                       plast_q;

  logic                       acc;
  logic                       acc_load, acc_step;
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0]      ax, ay, steps;
  logic [FRAC_BITS:0]         qx, qy, mx, my;
  logic signed [INC_BITS-1:0] inc_x, inc_y;
  logic signed [POS_BITS-1:0] tx, ty;
  dda_div_ctrl_t              dctrl;

  // Handshake: one output slot, no input while dividing.
  assign in_i.ready = (state_q == ST_IDLE) && (!ovalid_q || pix_o.ready);
  assign acc        = in_i.valid && in_i.ready;
  assign acc_load   = acc && (in_i.opcode == OP_LOAD);
  assign acc_step   = acc && (in_i.opcode == OP_STEP) && busy_q;

  // Line set-up: deltas, magnitudes and step count.
  always_comb begin
    dx    = {in_i.x_end[COORD_BITS-1], in_i.x_end} - {in_i.x_start[COORD_BITS-1], in_i.x_start};
    dy    = {in_i.y_end[COORD_BITS-1], in_i.y_end} - {in_i.y_start[COORD_BITS-1], in_i.y_start};
    ax    = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ay    = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    steps = (ax > ay) ? ax : ay;
  end

  // The dividers produce both increments in parallel.
  assign dctrl.load  = acc_load;
  assign dctrl.shift = (state_q == ST_DIV);

  dda_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dctrl),
    .mag_i  (ax),
    .steps_i(steps),
    .quot_o (qx)
  );

  dda_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dctrl),
    .mag_i  (ay),
    .steps_i(steps),
    .quot_o (qy)
  );

  // Signed increments; a zero-length line walks nowhere.
  always_comb begin
    mx    = zero_q ? '0 : qx;
    my    = zero_q ? '0 : qy;
    inc_x = neg_x_q ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
    inc_y = neg_y_q ? -$signed({1'b0, my}) : $signed({1'b0, my});
  end

  // Truncation toward zero: bias negative positions before the shift.
  always_comb begin
    tx = pos_x_q + (pos_x_q[POS_BITS-1] ? POS_BITS'((1 << FRAC_BITS) - 1) : POS_BITS'(0));
    ty = pos_y_q + (pos_y_q[POS_BITS-1] ? POS_BITS'((1 << FRAC_BITS) - 1) : POS_BITS'(0));
  end

  // Sequencer next state.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    ovalid_d = ovalid_q && !pix_o.ready;
    case (state_q)
      ST_IDLE: begin
        if (acc_load) begin
          state_d = ST_DIV;
          cnt_d   = '0;
          busy_d  = 1'b1;
        end else if (acc_step) begin
          ovalid_d = 1'b1;
          if (left_q == '0) begin
            busy_d = 1'b0;
          end
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(FRAC_BITS)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Line state: load sets it up, each pixel but the last advances it.
  always_ff @(posedge clk_i) begin
    if (acc_load) begin
      pos_x_q <= POS_BITS'(signed'(in_i.x_start)) <<< FRAC_BITS;
      pos_y_q <= POS_BITS'(signed'(in_i.y_start)) <<< FRAC_BITS;
      neg_x_q <= dx[COORD_BITS];
      neg_y_q <= dy[COORD_BITS];
      zero_q  <= (steps == '0);
      left_q  <= steps;
      color_q <= in_i.line_color;
    end else if (acc_step && (left_q != '0)) begin
      pos_x_q <= pos_x_q + POS_BITS'(inc_x);
      pos_y_q <= pos_y_q + POS_BITS'(inc_y);
      left_q  <= left_q - COORD_BITS'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (acc_step) begin
      px_q    <= tx[COORD_BITS+FRAC_BITS-1:FRAC_BITS];
      py_q    <= ty[COORD_BITS+FRAC_BITS-1:FRAC_BITS];
      pcol_q  <= color_q;
      plast_q <= (left_q == '0);
    end
  end

  assign pix_o.valid       = ovalid_q;
  assign pix_o.pixel_x     = px_q;
  assign pix_o.pixel_y     = py_q;
  assign pix_o.pixel_color = pcol_q;
  assign pix_o.last_pixel  = plast_q;

endmodule

`default_nettype wire

### sv/dda_div.sv
// Bit-serial restoring divider for one axis: (mag << FRAC_BITS) / steps,
// one quotient bit per cycle while shift is set, into a shift register. Depends on dda_pkg.
`default_nettype none

module dda_div #(
  parameter int COORD_BITS = dda_pkg::DDA_COORD_BITS,
  parameter int FRAC_BITS  = dda_pkg::DDA_FRAC_BITS
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire dda_pkg::dda_div_ctrl_t  ctrl_i,
  input  wire  [COORD_BITS-1:0]        mag_i,
  input  wire  [COORD_BITS-1:0]        steps_i,
  output logic [FRAC_BITS:0]           quot_o
);
  import dda_pkg::*;

  // Partial remainder is kept below the divisor, so one extra bit covers the doubling.
  logic [COORD_BITS:0]   rem_q, rem_d;
  logic [COORD_BITS-1:0] div_q, div_d;
  logic [FRAC_BITS:0]    quot_q, quot_d;
  logic [COORD_BITS:0]   diff;
  logic                  qbit;

  // One restoring step: compare, subtract, shift in a zero dividend bit.
  always_comb begin
    diff   = rem_q - {1'b0, div_q};
    qbit   = (rem_q >= {1'b0, div_q});
    rem_d  = rem_q;
    div_d  = div_q;
    quot_d = quot_q;
    if (ctrl_i.load) begin
      rem_d  = {1'b0, mag_i};
      div_d  = steps_i;
      quot_d = '0;
    end else if (ctrl_i.shift) begin
      rem_d  = qbit ? {diff[COORD_BITS-1:0], 1'b0} : {rem_q[COORD_BITS-1:0], 1'b0};
      quot_d = {quot_q[FRAC_BITS-1:0], qbit};
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      div_q  <= '0;
      quot_q <= '0;
    end else begin
      rem_q  <= rem_d;
      div_q  <= div_d;
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

### tb/dda_line_checker.sv
// Checker for the DDA line rasteriser: watches both channels, models the line walk
// and compares every delivered pixel. Depends on dda_pkg, dda_in_if and dda_pix_if.
`default_nettype none

module dda_line_checker #(
  parameter int COORD_BITS = dda_pkg::DDA_COORD_BITS,
  parameter int FRAC_BITS  = dda_pkg::DDA_FRAC_BITS
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  dda_in_if            in_i,
  dda_pix_if           pix_i,
  output int unsigned  fail_count_o,
  output int unsigned  pixels_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import dda_pkg::*;

  localparam int PW = COORD_BITS + FRAC_BITS + 1;  // fixed-point position width
  localparam int IW = FRAC_BITS + 2;               // fixed-point increment width

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [DDA_COLOR_BITS-1:0]    rgb;
    logic                         last;
  } pixel_t;

  pixel_t expected_pixels[$];

  // Model of the line being walked.
  logic signed [PW-1:0]      pos_x, pos_y;
  logic signed [IW-1:0]      inc_x, inc_y;
  logic [COORD_BITS:0]       steps_left;
  logic                      line_active;
  logic [DDA_COLOR_BITS-1:0] line_rgb;

  int unsigned fails = 0;
  int unsigned owed  = 0;

  assign fail_count_o  = fails;
  assign pixels_owed_o = owed;

  // Per-step increment: delta over step count, rounded toward zero.
  function automatic logic signed [IW-1:0] slope_inc(logic signed [COORD_BITS:0] d,
                                                     logic [COORD_BITS:0] n);
    logic [COORD_BITS:0]         m;
    logic [COORD_BITS+FRAC_BITS:0] q;
    if (n == '0) return '0;
    m = d[COORD_BITS] ? -d : d;
    q = {m, {FRAC_BITS{1'b0}}} / n;
    return d[COORD_BITS] ? -q[IW-1:0] : q[IW-1:0];
  endfunction

  // Integer part of a position, truncated toward zero.
  function automatic logic [COORD_BITS-1:0] whole_part(logic signed [PW-1:0] p);
    logic [PW-1:0] m;
    m = p[PW-1] ? -p : p;
    m = m >> FRAC_BITS;
    if (p[PW-1]) m = -m;
    return m[COORD_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    pixel_t                     got;
    pixel_t                     want;
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]        ax, ay, span;
    if (!rst_ni) begin
      expected_pixels.delete();
      pos_x       = '0;
      pos_y       = '0;
      inc_x       = '0;
      inc_y       = '0;
      steps_left  = '0;
      line_active = 1'b0;
      line_rgb    = '0;
    end else begin
      // A delivered pixel is checked against the oldest prediction.
      if (pix_i.valid && pix_i.ready) begin
        got = '{pix_i.pixel_x, pix_i.pixel_y, pix_i.pixel_color, pix_i.last_pixel};
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel: pixel_x %0d pixel_y %0d", got.x, got.y);
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.x !== want.x) begin
            $error("pixel_x: expected %0d, got %0d", want.x, got.x);
            fails++;
          end
          if (got.y !== want.y) begin
            $error("pixel_y: expected %0d, got %0d", want.y, got.y);
            fails++;
          end
          if (got.rgb !== want.rgb) begin
            $error("pixel_color: expected %06h, got %06h", want.rgb, got.rgb);
            fails++;
          end
          if (got.last !== want.last) begin
            $error("last_pixel: expected %0b, got %0b", want.last, got.last);
            fails++;
          end
        end
      end
      // An accepted transaction either sets up a line or, while a line is active, walks one step.
      if (in_i.valid && in_i.ready) begin
        if (in_i.opcode == OP_LOAD) begin
          dx   = in_i.x_end - in_i.x_start;
          dy   = in_i.y_end - in_i.y_start;
          ax   = dx[COORD_BITS] ? -dx : dx;
          ay   = dy[COORD_BITS] ? -dy : dy;
          span = (ax > ay) ? ax : ay;
          inc_x       = slope_inc(dx, span);
          inc_y       = slope_inc(dy, span);
          pos_x       = {in_i.x_start[COORD_BITS-1], in_i.x_start, {FRAC_BITS{1'b0}}};
          pos_y       = {in_i.y_start[COORD_BITS-1], in_i.y_start, {FRAC_BITS{1'b0}}};
          steps_left  = span;
          line_rgb    = in_i.line_color;
          line_active = 1'b1;
        end else if (line_active) begin
          want = '{whole_part(pos_x), whole_part(pos_y), line_rgb, steps_left == '0};
          expected_pixels.push_back(want);
          if (steps_left == '0) begin
            line_active = 1'b0;
          end else begin
            pos_x      = pos_x + inc_x;
            pos_y      = pos_y + inc_y;
            steps_left = steps_left - 1'b1;
          end
        end
      end
    end
    owed = expected_pixels.size();
  end

endmodule

`default_nettype wire

### tb/dda_line_rasterizer_tb.sv
// Top of the DDA line rasteriser testbench: clock, reset, command stimulus and
// verdict. Depends on dda_pkg, both channel interfaces, the block and dda_line_checker.
`default_nettype none

module dda_line_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dda_pkg::*;

  localparam int COORD_BITS = DDA_COORD_BITS;
  localparam int FRAC_BITS  = DDA_FRAC_BITS;
  localparam int CMD_TARGET = 700;
  localparam int COORD_MIN  = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int          idle_pct = 29;
  int unsigned fail_count;
  int unsigned pixels_owed;

  dda_in_if  #(.COORD_BITS(COORD_BITS)) in_if ();
  dda_pix_if #(.COORD_BITS(COORD_BITS)) pix_if ();

  dda_line_rasterizer #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .pix_o  (pix_if)
  );

  dda_line_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_if),
    .pix_i         (pix_if),
    .fail_count_o  (fail_count),
    .pixels_owed_o (pixels_owed)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // The pixel sink stalls at random at the same rate as the sender idles.
  always @(posedge clk_i) begin
    pix_if.ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #400_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int clamp_coord(int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int line_steps(int xs, int ys, int xe, int ye);
    int ax, ay;
    ax = (xe > xs) ? xe - xs : xs - xe;
    ay = (ye > ys) ? ye - ys : ys - ye;
    return (ax > ay) ? ax : ay;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Offers one command transaction, with random idle cycles ahead of it.
  task automatic send_cmd(input logic op, input int xs, input int ys, input int xe,
                          input int ye, input logic [DDA_COLOR_BITS-1:0] rgb);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.x_start    <= xs[COORD_BITS-1:0];
    in_if.y_start    <= ys[COORD_BITS-1:0];
    in_if.x_end      <= xe[COORD_BITS-1:0];
    in_if.y_end      <= ye[COORD_BITS-1:0];
    in_if.line_color <= rgb;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // A step carries random payload, which the block must ignore.
  task automatic send_step();
    send_cmd(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             DDA_COLOR_BITS'($urandom));
  endtask

  task automatic send_line(input int xs, input int ys, input int xe, input int ye,
                           input logic [DDA_COLOR_BITS-1:0] rgb, input int n_steps);
    send_cmd(OP_LOAD, xs, ys, xe, ye, rgb);
    repeat (n_steps) send_step();
  endtask

  // Stops sending until every predicted pixel has been delivered.
  task automatic drain_pixels();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pixels_owed == 0);
  endtask

  initial begin
    int issued;
    int seq_no;
    int pick;
    int xs, ys, xe, ye;
    int reach;
    int n;

    in_if.valid      <= 1'b0;
    in_if.opcode     <= OP_LOAD;
    in_if.x_start    <= '0;
    in_if.y_start    <= '0;
    in_if.x_end      <= '0;
    in_if.y_end      <= '0;
    in_if.line_color <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a step before any line, a single-point line and a step after it ends.
    send_step();
    send_line(0, 0, 0, 0, 24'hFFFFFF, 1);
    send_step();
    // Full-range diagonals, each cut short by the following load.
    send_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 24'h000000, 3);
    send_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 24'hFFFFFF, 2);
    // A short line crossing zero in x, walked to its end and one step beyond.
    send_line(5, 3, -2, 7, 24'hA5A5A5, 9);
    // Fractional positions must truncate toward zero.
    send_line(0, 0, -3, 1, 24'h5A5A5A, 4);
    drain_pixels();

    // Random: mostly complete short lines, some interrupted long ones, some noise.
    issued = 0;
    seq_no = 0;
    while (issued < CMD_TARGET) begin
      seq_no++;
      idle_pct <= (issued >= 300 && issued < 420) ? 0 : 29;
      if (seq_no % 50 == 0) drain_pixels();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        xs = rand_coord();
        ys = rand_coord();
        if ($urandom_range(0, 7) == 0) xs = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        if ($urandom_range(0, 7) == 0) ys = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        reach = ($urandom_range(0, 9) == 0) ? 60 : 12;
        xe = clamp_coord(xs + int'($urandom_range(0, 2 * reach)) - reach);
        ye = clamp_coord(ys + int'($urandom_range(0, 2 * reach)) - reach);
        n  = line_steps(xs, ys, xe, ye);
        send_line(xs, ys, xe, ye, DDA_COLOR_BITS'($urandom), n + 1);
        issued += n + 2;
        if ($urandom_range(0, 3) == 0) begin
          send_step();
          issued++;
        end
      end else if (pick < 88) begin
        n = $urandom_range(0, 6);
        send_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  DDA_COLOR_BITS'($urandom), n);
        issued += n + 1;
      end else begin
        send_cmd(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), DDA_COLOR_BITS'($urandom));
        issued++;
      end
    end

    // Let the last pixels and any division in flight finish.
    drain_pixels();
    repeat (FRAC_BITS + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
sv/dda_pkg.sv
sv/dda_in_if.sv
sv/dda_pix_if.sv
sv/dda_div.sv
sv/dda_line_rasterizer.sv
tb/dda_line_checker.sv
tb/dda_line_rasterizer_tb.sv
